>>> rtl/bph_pkg.sv
package bph_pkg;

	// beat field widths
	localparam int CMD_W        = 2;
	localparam int ADDR_W       = 32;
	localparam int PATTERN_W    = 8;
	localparam int TRACKED_W    = 7;
	localparam int READ_COUNT_W = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_BRANCH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// configuration register widths and reset values
	localparam int CSB_W  = 3;
	localparam int HSB_W  = 3;
	localparam int HLEN_W = 4;
	localparam logic [CSB_W-1:0]  COUNT_SLOT_BITS_RST   = 3'd6;
	localparam logic [HSB_W-1:0]  HISTORY_SLOT_BITS_RST = 3'd6;
	localparam logic [HLEN_W-1:0] HISTORY_LENGTH_RST    = 4'd8;

	// register file port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_SLOT_BITS   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HISTORY_SLOT_BITS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HISTORY_LENGTH    = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOKUP,
		ST_EXEC,
		ST_UPDATE,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic exec;
		logic update;
		logic sweep;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cmd_clear;
		logic sweep_last;
		logic result_busy;
	} dp_status_t;

endpackage

>>> rtl/bph_ram.sv
module bph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bph_ctrl.sv
module bph_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  bph_pkg::dp_status_t   status,
	output bph_pkg::ctrl_cmd_t    ctl
);

	import bph_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_nxt  = state_q;
		ctl        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				ctl.sweep = 1'b1;
				if (status.sweep_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					ctl.capture = 1'b1;
					state_nxt   = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				ctl.lookup = 1'b1;
				state_nxt  = ST_EXEC;
			end
			ST_EXEC: begin
				ctl.exec  = 1'b1;
				state_nxt = status.cmd_clear ? ST_CLEAR : ST_UPDATE;
			end
			ST_UPDATE: begin
				ctl.update = 1'b1;
				state_nxt  = ST_DONE;
			end
			ST_CLEAR: begin
				ctl.sweep = 1'b1;
				if (status.sweep_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!status.result_busy) begin
					ctl.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_INIT;
			end
		endcase
	end

endmodule

>>> rtl/bph_dp.sv
module bph_dp #(
	parameter int SLOT_BITS_MAX = 6,
	parameter int HISTORY_MAX   = 8,
	parameter int COUNT_WIDTH   = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  bph_pkg::ctrl_cmd_t                        ctl,
	output bph_pkg::dp_status_t                       status,
	// input beat
	input  logic [bph_pkg::CMD_W-1:0]                 command,
	input  logic [bph_pkg::ADDR_W-1:0]                branch_address,
	input  logic                                      taken,
	input  logic                                      accept_new,
	input  logic [bph_pkg::PATTERN_W-1:0]             read_pattern,
	// configuration
	input  logic [bph_pkg::CSB_W-1:0]                 count_slot_bits,
	input  logic [bph_pkg::HSB_W-1:0]                 history_slot_bits,
	input  logic [bph_pkg::HLEN_W-1:0]                history_length,
	// result beat
	output logic                                      result_valid,
	input  logic                                      result_stall,
	output logic [bph_pkg::TRACKED_W-1:0]             tracked_slots,
	output logic [bph_pkg::READ_COUNT_W-1:0]          read_count,
	output logic                                      read_slot_valid,
	// history memory
	output logic                                      h_we,
	output logic [SLOT_BITS_MAX-1:0]                  h_waddr,
	output logic [HISTORY_MAX-1:0]                    h_wdata,
	output logic                                      h_re,
	output logic [SLOT_BITS_MAX-1:0]                  h_raddr,
	input  logic [HISTORY_MAX-1:0]                    h_rdata,
	// pattern counter memory
	output logic                                      c_we,
	output logic [SLOT_BITS_MAX+HISTORY_MAX-1:0]      c_waddr,
	output logic [COUNT_WIDTH-1:0]                    c_wdata,
	output logic                                      c_re,
	output logic [SLOT_BITS_MAX+HISTORY_MAX-1:0]      c_raddr,
	input  logic [COUNT_WIDTH-1:0]                    c_rdata
);

	import bph_pkg::*;

	localparam int SLOTS  = 1 << SLOT_BITS_MAX;
	localparam int CAW    = SLOT_BITS_MAX + HISTORY_MAX;
	localparam int PEXT_W = (HISTORY_MAX > PATTERN_W) ? HISTORY_MAX : PATTERN_W;
	localparam int CEXT_W = (COUNT_WIDTH > READ_COUNT_W) ? COUNT_WIDTH : READ_COUNT_W;

	logic [CMD_W-1:0]         command_q;
	logic [ADDR_W-1:0]        addr_q;
	logic                     taken_q;
	logic                     accept_q;
	logic [PATTERN_W-1:0]     pattern_q;

	logic [SLOT_BITS_MAX-1:0] cmask;
	logic [SLOT_BITS_MAX-1:0] hmask;
	logic [SLOT_BITS_MAX-1:0] cs;
	logic [SLOT_BITS_MAX-1:0] hs;
	logic [HISTORY_MAX-1:0]   lmask;
	logic [PEXT_W-1:0]        pat_ext;
	logic [HISTORY_MAX-1:0]   pat;
	logic [HISTORY_MAX-1:0]   hist_base;
	logic [HISTORY_MAX-1:0]   hist_new;

	logic                     is_branch;
	logic                     is_read;
	logic                     is_clear;
	logic                     hv;
	logic                     sv;
	logic                     create_slot;
	logic                     create_hist;
	logic                     shift;

	logic [SLOTS-1:0]         hist_valid_q;
	logic [SLOTS-1:0]         slot_valid_q;
	logic [TRACKED_W-1:0]     slot_total_q;

	logic                     count_en_q;
	logic                     rvalid_q;
	logic [CAW-1:0]           count_addr_q;
	logic [READ_COUNT_W-1:0]  rcount_q;
	logic [CEXT_W-1:0]        c_ext;
	logic [COUNT_WIDTH-1:0]   c_inc;
	logic [CAW-1:0]           sweep_q;

	logic                     result_valid_q;
	logic [TRACKED_W-1:0]     tracked_slots_q;
	logic [READ_COUNT_W-1:0]  read_count_q;
	logic                     read_slot_valid_q;

	// capture the accepted beat
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			command_q <= command;
			addr_q    <= branch_address;
			taken_q   <= taken;
			accept_q  <= accept_new;
			pattern_q <= read_pattern;
		end
	end

	// slot and history length masks, oversized settings saturate naturally
	always_comb begin
		for (int i = 0; i < SLOT_BITS_MAX; i++) begin
			cmask[i] = i < int'(count_slot_bits);
			hmask[i] = i < int'(history_slot_bits);
		end
		for (int i = 0; i < HISTORY_MAX; i++) begin
			lmask[i] = (i == 0) || (i < int'(history_length));
		end
	end

	assign cs      = addr_q[SLOT_BITS_MAX-1:0] & cmask;
	assign hs      = addr_q[SLOT_BITS_MAX-1:0] & hmask;
	assign pat_ext = PEXT_W'(pattern_q);
	assign pat     = pat_ext[HISTORY_MAX-1:0];

	// decode and slot lookups
	assign is_branch   = (command_q == CMD_BRANCH);
	assign is_read     = (command_q == CMD_READ);
	assign is_clear    = (command_q == CMD_CLEAR);
	assign hv          = hist_valid_q[hs];
	assign sv          = slot_valid_q[cs];
	assign create_slot = is_branch && accept_q && !sv;
	assign create_hist = is_branch && accept_q && !hv;
	assign shift       = is_branch && (accept_q || hv);

	// new history: a fresh register starts from zero
	assign hist_base = create_hist ? '0 : h_rdata;
	assign hist_new  = HISTORY_MAX'({hist_base, taken_q}) & lmask;

	// history memory read-modify-write
	assign h_re    = ctl.lookup;
	assign h_raddr = hs;
	assign h_we    = ctl.exec && shift;
	assign h_waddr = hs;
	assign h_wdata = hist_new;

	// valid bits and slot count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
			slot_valid_q <= '0;
			slot_total_q <= '0;
		end else if (ctl.exec) begin
			if (is_clear) begin
				hist_valid_q <= '0;
				slot_valid_q <= '0;
				slot_total_q <= '0;
			end else begin
				if (create_hist) begin
					hist_valid_q[hs] <= 1'b1;
				end
				if (create_slot) begin
					slot_valid_q[cs] <= 1'b1;
					slot_total_q     <= slot_total_q + TRACKED_W'(1);
				end
			end
		end
	end

	// counter read, issued with the history update
	assign c_re    = ctl.exec;
	assign c_raddr = is_read ? {cs, pat} : {cs, hist_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_en_q <= 1'b0;
			rvalid_q   <= 1'b0;
		end else if (ctl.exec) begin
			count_en_q <= is_branch && accept_q;
			rvalid_q   <= is_read && sv;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			count_addr_q <= c_raddr;
		end
	end

	// saturating increment and read value
	assign c_inc = (&c_rdata) ? c_rdata : c_rdata + COUNT_WIDTH'(1);
	assign c_ext = CEXT_W'(c_rdata);

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			rcount_q <= c_ext[READ_COUNT_W-1:0];
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctl.sweep) begin
			sweep_q <= sweep_q + CAW'(1);
		end
	end

	// counter write: sweep zeroes, update writes back the increment
	always_comb begin
		if (ctl.sweep) begin
			c_we    = 1'b1;
			c_waddr = sweep_q;
			c_wdata = '0;
		end else begin
			c_we    = ctl.update && count_en_q;
			c_waddr = count_addr_q;
			c_wdata = c_inc;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			tracked_slots_q   <= slot_total_q;
			read_count_q      <= rvalid_q ? rcount_q : '0;
			read_slot_valid_q <= rvalid_q;
		end
	end

	assign result_valid    = result_valid_q;
	assign tracked_slots   = tracked_slots_q;
	assign read_count      = read_count_q;
	assign read_slot_valid = read_slot_valid_q;

	// status to the controller
	assign status.cmd_clear   = is_clear;
	assign status.sweep_last  = &sweep_q;
	assign status.result_busy = result_valid_q && result_stall;

endmodule

>>> rtl/branch_pattern_histogram_top.sv
// Branch pattern histogram: each beat carries a branch event (command 0), a
// counter read (command 1) or a clear of all tables (command 2). A branch
// event shifts the outcome into the per-slot local history if accept_new is
// set or that history exists and, when accept_new is set, bumps the saturating
// counter the new history selects; a read returns one counter and whether its
// slot exists; every beat yields one result beat. The block takes one beat at
// a time: after acceptance a branch event, a read or an unused code passes the
// lookup, exec, update and done states, done holding while the result is
// stalled, before the next beat is taken: a history memory read-modify-write,
// then a counter memory read-modify-write, each memory with a registered read.
// A clear zeroes the whole counter memory one entry a cycle. After reset the
// same pass runs over all 2^(SLOT_BITS_MAX+HISTORY_MAX) entries
// (16384 by default) with item_stall high; config writes are taken throughout.
module branch_pattern_histogram_top #(
	parameter int SLOT_BITS_MAX = 6,
	parameter int HISTORY_MAX   = 8,
	parameter int COUNT_WIDTH   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// item channel
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [bph_pkg::CMD_W-1:0]         command,
	input  logic [bph_pkg::ADDR_W-1:0]        branch_address,
	input  logic                              taken,
	input  logic                              accept_new,
	input  logic [bph_pkg::PATTERN_W-1:0]     read_pattern,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [bph_pkg::TRACKED_W-1:0]     tracked_slots,
	output logic [bph_pkg::READ_COUNT_W-1:0]  read_count,
	output logic                              read_slot_valid,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bph_pkg::PADDR_W-1:0]       paddr,
	input  logic [bph_pkg::PDATA_W-1:0]       pwdata,
	output logic [bph_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	import bph_pkg::*;

	localparam int CAW = SLOT_BITS_MAX + HISTORY_MAX;

	logic [CSB_W-1:0]         count_slot_bits_q;
	logic [HSB_W-1:0]         history_slot_bits_q;
	logic [HLEN_W-1:0]        history_length_q;
	logic [REG_IDX_W-1:0]     reg_idx;
	logic                     cfg_write;

	ctrl_cmd_t                ctl;
	dp_status_t               status;

	logic                     h_we;
	logic [SLOT_BITS_MAX-1:0] h_waddr;
	logic [HISTORY_MAX-1:0]   h_wdata;
	logic                     h_re;
	logic [SLOT_BITS_MAX-1:0] h_raddr;
	logic [HISTORY_MAX-1:0]   h_rdata;

	logic                     c_we;
	logic [CAW-1:0]           c_waddr;
	logic [COUNT_WIDTH-1:0]   c_wdata;
	logic                     c_re;
	logic [CAW-1:0]           c_raddr;
	logic [COUNT_WIDTH-1:0]   c_rdata;

	// configuration registers
	assign pready    = 1'b1;
	assign reg_idx   = paddr[PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_slot_bits_q   <= COUNT_SLOT_BITS_RST;
			history_slot_bits_q <= HISTORY_SLOT_BITS_RST;
			history_length_q    <= HISTORY_LENGTH_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_COUNT_SLOT_BITS:   count_slot_bits_q   <= pwdata[CSB_W-1:0];
				REG_HISTORY_SLOT_BITS: history_slot_bits_q <= pwdata[HSB_W-1:0];
				REG_HISTORY_LENGTH:    history_length_q    <= pwdata[HLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			REG_COUNT_SLOT_BITS:   prdata = PDATA_W'(count_slot_bits_q);
			REG_HISTORY_SLOT_BITS: prdata = PDATA_W'(history_slot_bits_q);
			REG_HISTORY_LENGTH:    prdata = PDATA_W'(history_length_q);
			default:               prdata = '0;
		endcase
	end

	// sequencer
	bph_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.ctl        (ctl)
	);

	// datapath
	bph_dp #(
		.SLOT_BITS_MAX (SLOT_BITS_MAX),
		.HISTORY_MAX   (HISTORY_MAX),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.status            (status),
		.command           (command),
		.branch_address    (branch_address),
		.taken             (taken),
		.accept_new        (accept_new),
		.read_pattern      (read_pattern),
		.count_slot_bits   (count_slot_bits_q),
		.history_slot_bits (history_slot_bits_q),
		.history_length    (history_length_q),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.tracked_slots     (tracked_slots),
		.read_count        (read_count),
		.read_slot_valid   (read_slot_valid),
		.h_we              (h_we),
		.h_waddr           (h_waddr),
		.h_wdata           (h_wdata),
		.h_re              (h_re),
		.h_raddr           (h_raddr),
		.h_rdata           (h_rdata),
		.c_we              (c_we),
		.c_waddr           (c_waddr),
		.c_wdata           (c_wdata),
		.c_re              (c_re),
		.c_raddr           (c_raddr),
		.c_rdata           (c_rdata)
	);

	// per-slot history registers
	bph_ram #(
		.WIDTH (HISTORY_MAX),
		.DEPTH (1 << SLOT_BITS_MAX)
	) u_hist_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// pattern counters, slot in the upper address bits
	bph_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (1 << CAW)
	) u_count_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

`ifndef SYNTHESIS
	// counter memory never reads and writes in the same cycle
	a_count_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(c_we && c_re))
		else $error("counter memory read and write overlap");

	// one beat in flight: acceptance closes the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input open right after an accepted beat");

	// a new result comes only as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !item_stall)
		else $error("result raised while the sequencer is busy");
`endif

endmodule

>>> tb/bph_checker.sv
// scoreboard for the branch pattern histogram: tracks the register file,
// predicts one result per accepted item beat and compares result beats
module bph_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_stall,
	input  logic [bph_pkg::CMD_W-1:0]        command,
	input  logic [bph_pkg::ADDR_W-1:0]       branch_address,
	input  logic                             taken,
	input  logic                             accept_new,
	input  logic [bph_pkg::PATTERN_W-1:0]    read_pattern,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  logic [bph_pkg::TRACKED_W-1:0]    tracked_slots,
	input  logic [bph_pkg::READ_COUNT_W-1:0] read_count,
	input  logic                             read_slot_valid,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [bph_pkg::PADDR_W-1:0]      paddr,
	input  logic [bph_pkg::PDATA_W-1:0]      pwdata,
	output int                               fail_count,
	output int                               pending
);

	import bph_pkg::*;

	localparam int SLOT_MAX = 6;
	localparam int HIST_MAX = 8;
	localparam int CNT_W    = 32;
	localparam int NSLOTS   = 1 << SLOT_MAX;
	localparam int NPAT     = 1 << HIST_MAX;

	typedef struct packed {
		logic [TRACKED_W-1:0]    tracked;
		logic [READ_COUNT_W-1:0] count;
		logic                    slot_ok;
	} histo_result_t;

	// shadow of the register file
	logic [CSB_W-1:0]  cnt_bits;
	logic [HSB_W-1:0]  hist_bits;
	logic [HLEN_W-1:0] hist_len;

	// shadow of the histogram tables
	logic [HIST_MAX-1:0] hist_reg [NSLOTS];
	bit                  hist_live [NSLOTS];
	bit                  slot_live [NSLOTS];
	logic [CNT_W-1:0]    pat_count [NSLOTS*NPAT];
	logic [TRACKED_W-1:0] slot_total_q;

	histo_result_t expected_results[$];

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	function automatic int slot_of(input logic [ADDR_W-1:0] addr, input int bits);
		int b;
		b = (bits > SLOT_MAX) ? SLOT_MAX : bits;
		return int'(addr & ((32'd1 << b) - 32'd1));
	endfunction

	task automatic clear_histogram();
		for (int i = 0; i < NSLOTS; i++) begin
			hist_reg[i] = '0;
			hist_live[i] = 1'b0;
			slot_live[i] = 1'b0;
		end
		for (int i = 0; i < NSLOTS*NPAT; i++)
			pat_count[i] = '0;
		slot_total_q = '0;
	endtask

	// advance the shadow tables by one item beat and queue its result
	task automatic histogram_step(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic tk, input logic acc, input logic [PATTERN_W-1:0] pat);
		int hs;
		int cs;
		int len;
		int idx;
		logic [HIST_MAX-1:0] h;
		histo_result_t r;
		r = '0;
		case (cmd)
			CMD_BRANCH: begin
				hs = slot_of(addr, int'(hist_bits));
				cs = slot_of(addr, int'(cnt_bits));
				len = int'(hist_len);
				if (len < 1) len = 1;
				if (len > HIST_MAX) len = HIST_MAX;
				// create missing slots
				if (acc && !slot_live[cs]) begin
					slot_live[cs] = 1'b1;
					slot_total_q = slot_total_q + 1'b1;
					for (int p = 0; p < NPAT; p++)
						pat_count[cs*NPAT + p] = '0;
				end
				if (acc && !hist_live[hs]) begin
					hist_live[hs] = 1'b1;
					hist_reg[hs] = '0;
				end
				// shift history, bump the selected counter with saturation
				if (acc || hist_live[hs]) begin
					h = HIST_MAX'(((32'(hist_reg[hs]) << 1) | 32'(tk)) & ((32'd1 << len) - 32'd1));
					hist_reg[hs] = h;
					if (acc) begin
						idx = cs*NPAT + int'(h);
						if (pat_count[idx] != '1)
							pat_count[idx] = pat_count[idx] + 1'b1;
					end
				end
			end
			CMD_READ: begin
				cs = slot_of(addr, int'(cnt_bits));
				if (slot_live[cs]) begin
					r.slot_ok = 1'b1;
					r.count = READ_COUNT_W'(pat_count[cs*NPAT + int'(pat)]);
				end
			end
			CMD_CLEAR: clear_histogram();
			default: ;
		endcase
		r.tracked = slot_total_q;
		expected_results.insert(expected_results.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		histo_result_t exp_r;
		if (!arst_n) begin
			cnt_bits = COUNT_SLOT_BITS_RST;
			hist_bits = HISTORY_SLOT_BITS_RST;
			hist_len = HISTORY_LENGTH_RST;
			clear_histogram();
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// item beat accepted
			if (item_valid && !item_stall)
				histogram_step(command, branch_address, taken, accept_new, read_pattern);
			// result beat accepted
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					exp_r = expected_results.pop_front();
					if (tracked_slots !== exp_r.tracked)
						report_mismatch($sformatf("tracked_slots %0d, expected %0d",
							tracked_slots, exp_r.tracked));
					if (read_count !== exp_r.count)
						report_mismatch($sformatf("read_count %0d, expected %0d",
							read_count, exp_r.count));
					if (read_slot_valid !== exp_r.slot_ok)
						report_mismatch($sformatf("read_slot_valid %0b, expected %0b",
							read_slot_valid, exp_r.slot_ok));
				end
			end
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_COUNT_SLOT_BITS:   cnt_bits = pwdata[CSB_W-1:0];
					REG_HISTORY_SLOT_BITS: hist_bits = pwdata[HSB_W-1:0];
					REG_HISTORY_LENGTH:    hist_len = pwdata[HLEN_W-1:0];
					default: ;
				endcase
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
module tb_top;
	import bph_pkg::*;

	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 142;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int POOL_SIZE   = 8;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	logic [CMD_W-1:0]        command = CMD_BRANCH;
	logic [ADDR_W-1:0]       branch_address = '0;
	logic                    taken = 1'b0;
	logic                    accept_new = 1'b0;
	logic [PATTERN_W-1:0]    read_pattern = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [TRACKED_W-1:0]    tracked_slots;
	logic [READ_COUNT_W-1:0] read_count;
	logic                    read_slot_valid;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [PADDR_W-1:0]      paddr = '0;
	logic [PDATA_W-1:0]      pwdata = '0;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int clears_left = 6;
	int hist_len_now = 8;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	branch_pattern_histogram_top u_top (.*);

	bph_checker u_checker (.*);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side back-pressure, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// offer one item beat, returns at the edge where it is taken
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic tk, input logic acc, input logic [PATTERN_W-1:0] pat);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		branch_address <= addr;
		taken <= tk;
		accept_new <= acc;
		read_pattern <= pat;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// mostly branch traffic on a small address pool, reads on the same pool, rare clears
	task automatic random_beat();
		int r;
		int len;
		logic [ADDR_W-1:0] addr;
		logic [PATTERN_W-1:0] pat;
		r = $urandom_range(999);
		addr = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(POOL_SIZE-1)] : $urandom;
		len = (hist_len_now < 1) ? 1 : (hist_len_now > 8) ? 8 : hist_len_now;
		pat = ($urandom_range(99) < 80) ? PATTERN_W'($urandom & ((1 << len) - 1))
			: PATTERN_W'($urandom);
		if (r < 4 && clears_left > 0) begin
			clears_left--;
			send_beat(CMD_CLEAR, $urandom, 1'($urandom), 1'($urandom), PATTERN_W'($urandom));
		end else if (r < 60) begin
			send_beat(CMD_UNUSED, $urandom, 1'($urandom), 1'($urandom), PATTERN_W'($urandom));
		end else if (r < 330) begin
			send_beat(CMD_READ, addr, 1'($urandom), 1'($urandom), pat);
		end else begin
			send_beat(CMD_BRANCH, addr, 1'($urandom), ($urandom_range(99) < 85),
				PATTERN_W'($urandom));
		end
	endtask

	initial begin
		int csb;
		int hsb;
		int hlen;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// idling mode of this phase
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 65; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 65; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase

			// register settings, extremes first
			case (ph)
				0: begin csb = 6; hsb = 6; hlen = 8;  end
				1: begin csb = 0; hsb = 0; hlen = 1;  end
				2: begin csb = 7; hsb = 7; hlen = 15; end
				3: begin csb = 2; hsb = 5; hlen = 0;  end
				4: begin csb = 6; hsb = 0; hlen = 8;  end
				5: begin csb = 1; hsb = 3; hlen = 3;  end
				default: begin
					csb = $urandom_range(7);
					hsb = $urandom_range(7);
					hlen = $urandom_range(15);
				end
			endcase
			apb_write(REG_COUNT_SLOT_BITS, PDATA_W'(csb));
			apb_write(REG_HISTORY_SLOT_BITS, PDATA_W'(hsb));
			apb_write(REG_HISTORY_LENGTH, PDATA_W'(hlen));
			hist_len_now = hlen;
			for (int i = 0; i < POOL_SIZE; i++)
				addr_pool[i] = $urandom;

			// directed beats on the reset settings
			if (ph == 0) begin
				send_beat(CMD_READ,   32'h0000_0000, 1'b0, 1'b0, 8'h00);
				send_beat(CMD_BRANCH, 32'h0000_0005, 1'b1, 1'b0, 8'h00);
				send_beat(CMD_BRANCH, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'h00);
				send_beat(CMD_BRANCH, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF);
				send_beat(CMD_BRANCH, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00);
				send_beat(CMD_BRANCH, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'h00);
				send_beat(CMD_READ,   32'hFFFF_FFFF, 1'b0, 1'b0, 8'h01);
				send_beat(CMD_READ,   32'hFFFF_FFFF, 1'b1, 1'b1, 8'h03);
				send_beat(CMD_READ,   32'hFFFF_FFFF, 1'b0, 1'b0, 8'h06);
				send_beat(CMD_READ,   32'h0000_003F, 1'b0, 1'b0, 8'hFF);
				send_beat(CMD_BRANCH, 32'h0000_0000, 1'b0, 1'b1, 8'h00);
				send_beat(CMD_BRANCH, 32'h8000_0040, 1'b1, 1'b1, 8'h00);
				send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF);
				send_beat(CMD_READ,   32'h0000_0000, 1'b0, 1'b0, 8'h01);
				send_beat(CMD_CLEAR,  32'h0000_0000, 1'b0, 1'b0, 8'h00);
				send_beat(CMD_READ,   32'hFFFF_FFFF, 1'b0, 1'b0, 8'h0D);
				send_beat(CMD_BRANCH, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00);
				send_beat(CMD_READ,   32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00);
			end

			// random traffic, with one long result hold-off in the first phase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 40)
					hold_req = 1'b1;
				random_beat();
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/bph_pkg.sv
rtl/bph_ram.sv
rtl/bph_ctrl.sv
rtl/bph_dp.sv
rtl/branch_pattern_histogram_top.sv
tb/bph_checker.sv
tb/tb_top.sv
